[rtl/core/jfc_pkg.sv]
// ---------------------------------------------------------------------------
// Joint friction compensation package
// Types and constants shared by the lanes, the merge stage and the top level.
// ---------------------------------------------------------------------------
package jfc_pkg;

  localparam int NumJoints = 3;
  localparam int AngleW    = 32;
  localparam int CoefW     = 16;
  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 48;
  localparam int InDataW   = NumJoints * AngleW;
  localparam int OutDataW  = 2 * NumJoints * AngleW;

  localparam logic [CoefW-1:0] FRIC_SCALE_RESET = 16'd4096;

  // Register indexes of the configuration port.
  typedef enum logic [CfgIdxW-1:0] {
    REG_VISC_POS   = 3'd0,
    REG_VISC_NEG   = 3'd1,
    REG_COUL_POS   = 3'd2,
    REG_COUL_NEG   = 3'd3,
    REG_DB_SLOPE   = 3'd4,
    REG_THRESH     = 3'd5,
    REG_FRIC_SCALE = 3'd6
  } cfg_reg_t;

  // Coefficients of one joint, each a Q4.12 lane of the packed registers.
  typedef struct packed {
    logic [CoefW-1:0] visc_pos;
    logic [CoefW-1:0] visc_neg;
    logic [CoefW-1:0] coul_pos;
    logic [CoefW-1:0] coul_neg;
    logic [CoefW-1:0] slope;
    logic [CoefW-1:0] thresh;
  } lane_coef_t;

  // Control from the top level to each lane.
  typedef struct packed {
    logic start;
    logic ack;
  } lane_ctrl_t;

  // Finished result of one lane.
  typedef struct packed {
    logic [AngleW-1:0] torque;
    logic [AngleW-1:0] vel;
  } lane_res_t;

endpackage

[rtl/core/joint_friction_compensation_core.sv]
// ---------------------------------------------------------------------------
// Joint friction compensation core
// Three joint lanes estimate filtered velocity and Coulomb plus viscous
// friction torque from one sample of joint angles.
// ---------------------------------------------------------------------------
//  Channel   Direction  Payload
//  in_       slave      tdata: angle_joint1..3, 32 bits each
//  out_      master     tdata: friction_torque_joint1..3, velocity_joint1..3
//  cfg_      write      cfg_index selects one of seven registers
//
// An accepted item steps each lane through the divide, velocity, multiply,
// scale and saturate states to a valid result. The input reopens on the edge
// the result enters the output register; until then no new item is taken.
// The divide-by-three unit in each lane (two quotient bytes a cycle) is
// followed by the coefficient and scale multipliers.
// Reset is synchronous; it clears the per-joint history and returns the
// configuration registers to their reset values, the scale to one.
// A stalled output holds in its register while the lanes finish the next item.
// ---------------------------------------------------------------------------
module joint_friction_compensation_core (
  input  logic                              clk,
  input  logic                              rst_n,
  // angle_joint1 [31:0], angle_joint2 [63:32], angle_joint3 [95:64]
  input  logic [jfc_pkg::InDataW-1:0]       in_tdata,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // friction_torque_joint1..3 [95:0], velocity_joint1..3 [191:96]
  output logic [jfc_pkg::OutDataW-1:0]      out_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  input  logic                              cfg_we,
  input  logic [jfc_pkg::CfgIdxW-1:0]       cfg_index,
  input  logic [jfc_pkg::CfgDataW-1:0]      cfg_wdata
);

  localparam int NJ = jfc_pkg::NumJoints;
  localparam int CW = jfc_pkg::CoefW;
  localparam int AW = jfc_pkg::AngleW;

  logic [jfc_pkg::CfgDataW-1:0] visc_pos_r;
  logic [jfc_pkg::CfgDataW-1:0] visc_neg_r;
  logic [jfc_pkg::CfgDataW-1:0] coul_pos_r;
  logic [jfc_pkg::CfgDataW-1:0] coul_neg_r;
  logic [jfc_pkg::CfgDataW-1:0] slope_r;
  logic [jfc_pkg::CfgDataW-1:0] thresh_r;
  logic [CW-1:0]                scale_r;
  logic                         busy_r;

  logic                         in_accept;
  logic                         lane_ack;
  logic [NJ-1:0]                lane_done;
  jfc_pkg::lane_res_t           lane_res [NJ];
  jfc_pkg::lane_ctrl_t          lane_ctrl;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      visc_pos_r <= '0;
      visc_neg_r <= '0;
      coul_pos_r <= '0;
      coul_neg_r <= '0;
      slope_r    <= '0;
      thresh_r   <= '0;
      scale_r    <= jfc_pkg::FRIC_SCALE_RESET;
    end else if (cfg_we) begin
      unique case (jfc_pkg::cfg_reg_t'(cfg_index))
        jfc_pkg::REG_VISC_POS:   visc_pos_r <= cfg_wdata;
        jfc_pkg::REG_VISC_NEG:   visc_neg_r <= cfg_wdata;
        jfc_pkg::REG_COUL_POS:   coul_pos_r <= cfg_wdata;
        jfc_pkg::REG_COUL_NEG:   coul_neg_r <= cfg_wdata;
        jfc_pkg::REG_DB_SLOPE:   slope_r    <= cfg_wdata;
        jfc_pkg::REG_THRESH:     thresh_r   <= cfg_wdata;
        jfc_pkg::REG_FRIC_SCALE: scale_r    <= cfg_wdata[CW-1:0];
        default: begin
        end
      endcase
    end
  end

  // The lanes are busy from an input transaction until the merge takes them.
  assign in_accept = in_tvalid && in_tready;
  assign in_tready = !busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (in_accept) begin
      busy_r <= 1'b1;
    end else if (lane_ack) begin
      busy_r <= 1'b0;
    end
  end

  assign lane_ctrl.start = in_accept;
  assign lane_ctrl.ack   = lane_ack;

  // One lane per joint.
  for (genvar j = 0; j < NJ; j++) begin : g_lane
    jfc_pkg::lane_coef_t coef;

    assign coef.visc_pos = visc_pos_r[j*CW +: CW];
    assign coef.visc_neg = visc_neg_r[j*CW +: CW];
    assign coef.coul_pos = coul_pos_r[j*CW +: CW];
    assign coef.coul_neg = coul_neg_r[j*CW +: CW];
    assign coef.slope    = slope_r[j*CW +: CW];
    assign coef.thresh   = thresh_r[j*CW +: CW];

    jfc_lane u_lane (
      .clk   (clk),
      .rst_n (rst_n),
      .ctrl  (lane_ctrl),
      .angle (in_tdata[j*AW +: AW]),
      .coef  (coef),
      .scale (scale_r),
      .done  (lane_done[j]),
      .res   (lane_res[j])
    );
  end

  jfc_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .lane_done  (lane_done),
    .lane_res   (lane_res),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .lane_ack   (lane_ack)
  );

  // An accepted transaction keeps the input closed until the merge.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> !in_tready)
    else $error("input ready right after an accepted transaction");

  // All lanes run in lock-step.
  a_lanes_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    (lane_done[0] == lane_done[1]) && (lane_done[1] == lane_done[2]))
    else $error("lanes out of step");

  // The merge only takes finished lanes.
  a_ack_when_done: assert property (@(posedge clk) disable iff (!rst_n)
    lane_ack |-> (&lane_done))
    else $error("lane acknowledge without a finished result");

  // A new output transaction always comes from a merge.
  a_valid_from_merge: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(lane_ack))
    else $error("output valid without a merge");

  // Input is never taken while lanes still hold an unmerged result.
  a_no_accept_done: assert property (@(posedge clk) disable iff (!rst_n)
    (|lane_done) |-> !in_tready)
    else $error("input ready while lanes hold a result");

endmodule

[rtl/core/jfc_lane.sv]
// ---------------------------------------------------------------------------
// Joint friction compensation lane
// Velocity estimate, averaging filter and friction torque for one joint.
// ---------------------------------------------------------------------------
module jfc_lane (
  input  logic                              clk,
  input  logic                              rst_n,
  input  jfc_pkg::lane_ctrl_t               ctrl,
  input  logic        [jfc_pkg::AngleW-1:0] angle,
  input  jfc_pkg::lane_coef_t               coef,
  input  logic        [jfc_pkg::CoefW-1:0]  scale,
  output logic                              done,
  output jfc_pkg::lane_res_t                res
);

  localparam logic [20:0] DIV3_RECIP = 21'd683;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_VEL,
    S_MUL,
    S_SCALE,
    S_SAT,
    S_DONE
  } state_t;

  state_t             state_r;
  logic               done_r;
  logic signed [31:0] prev_r;
  logic signed [31:0] hist1_r;
  logic signed [31:0] hist2_r;
  logic               neg_r;
  logic        [47:0] mag_r;
  logic        [47:0] quot_r;
  logic        [1:0]  rem_r;
  logic        [1:0]  cnt_r;
  logic signed [31:0] vel_r;
  logic signed [15:0] coef_sel_r;
  logic signed [19:0] off_r;
  logic signed [47:0] prod_r;
  logic signed [53:0] scaled_r;
  logic        [31:0] torque_r;

  logic signed [43:0] diff_ext;
  logic signed [43:0] raw;
  logic signed [44:0] sum;
  logic        [44:0] sum_mag;
  logic        [9:0]  step_hi;
  logic        [9:0]  step_lo;
  logic signed [31:0] vel_sat;
  logic signed [32:0] vel_ext;
  logic signed [32:0] thr_ext;
  logic               br_pos;
  logic               br_neg;
  logic signed [47:0] prod;
  logic signed [36:0] u_sum;
  logic signed [53:0] scaled;
  logic signed [53:0] shifted;
  logic        [31:0] torque_sat;

  // One digit of a long division by three: remainder and byte in, digit and
  // remainder out. The reciprocal multiply is exact for values below 768.
  function automatic logic [9:0] div3_step(input logic [1:0] r, input logic [7:0] b);
    logic [9:0]  v;
    logic [20:0] p;
    logic [7:0]  q;
    logic [9:0]  t;
    v = {r, b};
    p = 21'(v) * DIV3_RECIP;
    q = p[18:11];
    t = v - 10'(q) * 10'd3;
    return {q, t[1:0]};
  endfunction

  // Raw velocity times 1000 plus both history terms.
  always_comb begin
    diff_ext = 44'($signed(angle)) - 44'(prev_r);
    raw      = diff_ext * 44'sd1000;
    sum      = 45'(raw) + 45'(hist1_r) + 45'(hist2_r);
    sum_mag  = sum[44] ? 45'(-sum) : 45'(sum);
  end

  // Two quotient bytes per cycle, most significant first.
  always_comb begin
    step_hi = div3_step(rem_r, mag_r[47:40]);
    step_lo = div3_step(step_hi[1:0], mag_r[39:32]);
  end

  // Restore the sign, saturate and pick the friction branch.
  always_comb begin
    if (!neg_r) begin
      vel_sat = (quot_r > 48'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(quot_r[31:0]);
    end else begin
      vel_sat = (quot_r > 48'h8000_0000) ? 32'sh8000_0000 : $signed(-quot_r[31:0]);
    end
    vel_ext = 33'(vel_sat);
    thr_ext = $signed({13'b0, coef.thresh, 4'b0});
    br_pos  = (vel_ext >= thr_ext);
    br_neg  = (vel_ext <= -thr_ext);
  end

  // Coefficient product, offset, global scale and torque saturation.
  always_comb begin
    prod    = 48'(coef_sel_r) * 48'(vel_r);
    u_sum   = 37'(prod_r >>> 12) + 37'(off_r);
    scaled  = 54'(u_sum) * 54'($signed({1'b0, scale}));
    shifted = scaled_r >>> 12;
    if (shifted > 54'sd2147483647) begin
      torque_sat = 32'h7FFF_FFFF;
    end else if (shifted < -54'sd2147483648) begin
      torque_sat = 32'h8000_0000;
    end else begin
      torque_sat = shifted[31:0];
    end
  end

  // Lane sequencer with its registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      done_r  <= 1'b0;
      prev_r  <= '0;
      hist1_r <= '0;
      hist2_r <= '0;
      cnt_r   <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (ctrl.start) begin
            prev_r  <= $signed(angle);
            neg_r   <= sum[44];
            mag_r   <= {3'b0, sum_mag};
            quot_r  <= '0;
            rem_r   <= '0;
            cnt_r   <= '0;
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          mag_r  <= mag_r << 16;
          quot_r <= {quot_r[31:0], step_hi[9:2], step_lo[9:2]};
          rem_r  <= step_lo[1:0];
          cnt_r  <= cnt_r + 2'd1;
          if (cnt_r == 2'd2) begin
            state_r <= S_VEL;
          end
        end
        S_VEL: begin
          vel_r   <= vel_sat;
          hist2_r <= hist1_r;
          hist1_r <= vel_sat;
          if (br_pos) begin
            coef_sel_r <= $signed(coef.visc_pos);
            off_r      <= $signed({coef.coul_pos, 4'b0});
          end else if (br_neg) begin
            coef_sel_r <= $signed(coef.visc_neg);
            off_r      <= $signed({coef.coul_neg, 4'b0});
          end else begin
            coef_sel_r <= $signed(coef.slope);
            off_r      <= '0;
          end
          state_r <= S_MUL;
        end
        S_MUL: begin
          prod_r  <= prod;
          state_r <= S_SCALE;
        end
        S_SCALE: begin
          scaled_r <= scaled;
          state_r  <= S_SAT;
        end
        S_SAT: begin
          torque_r <= torque_sat;
          done_r   <= 1'b1;
          state_r  <= S_DONE;
        end
        S_DONE: begin
          if (ctrl.ack) begin
            done_r  <= 1'b0;
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign done       = done_r;
  assign res.torque = torque_r;
  assign res.vel    = vel_r;

endmodule

[rtl/core/jfc_merge.sv]
// ---------------------------------------------------------------------------
// Joint friction compensation merge stage
// Collects the three lane results into the registered output transaction.
// ---------------------------------------------------------------------------
module jfc_merge (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic        [jfc_pkg::NumJoints-1:0] lane_done,
  input  jfc_pkg::lane_res_t                  lane_res [jfc_pkg::NumJoints],
  input  logic                                out_tready,
  output logic                                out_tvalid,
  output logic        [jfc_pkg::OutDataW-1:0] out_tdata,
  output logic                                lane_ack
);

  localparam int JointW = jfc_pkg::AngleW;
  localparam int VelOfs = jfc_pkg::NumJoints * JointW;

  logic                          out_valid_r;
  logic [jfc_pkg::OutDataW-1:0]  out_data_r;
  logic [jfc_pkg::OutDataW-1:0]  packed_res;
  logic                          load;

  // Torques in the low half, velocities above, joint one lowest.
  always_comb begin
    packed_res = '0;
    for (int j = 0; j < jfc_pkg::NumJoints; j++) begin
      packed_res[j*JointW +: JointW]          = lane_res[j].torque;
      packed_res[VelOfs + j*JointW +: JointW] = lane_res[j].vel;
    end
  end

  // Load when every lane has finished and the output register is free.
  assign load = (&lane_done) && (!out_valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
        out_data_r  <= packed_res;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign lane_ack   = load;

endmodule

[sim/tb.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Testbench for the joint friction compensation core
// Streams joint angle samples through the core under random back-pressure,
// predicts the filtered velocities and friction torques of every sample in
// a scoreboard and compares each result transaction field by field. The run
// walks through several register settings, the extremes among them.
// ---------------------------------------------------------------------------
module tb;

  localparam int     NumJoints     = jfc_pkg::NumJoints;
  localparam int     AngleW        = jfc_pkg::AngleW;
  localparam int     CoefW         = jfc_pkg::CoefW;
  localparam int     CfgIdxW       = jfc_pkg::CfgIdxW;
  localparam int     CfgDataW      = jfc_pkg::CfgDataW;
  localparam int     InDataW       = jfc_pkg::InDataW;
  localparam int     OutDataW      = jfc_pkg::OutDataW;
  localparam int     LatencyCycles = 8;
  localparam int     NumPhases     = 8;
  localparam int     ItemsPerPhase = 180;
  localparam longint SatHi         = 64'sd2147483647;
  localparam longint SatLo         = -64'sd2147483648;
  // An index past the last register; the core must ignore writes to it.
  localparam logic [CfgIdxW-1:0] RegUnmapped = 3'd7;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic [InDataW-1:0]   in_tdata = '0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [OutDataW-1:0]  out_tdata;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CfgIdxW-1:0]   cfg_index = '0;
  logic [CfgDataW-1:0]  cfg_wdata = '0;

  // Random idling on both channels is switched off for some phases.
  bit idling = 1'b1;
  int walk [NumJoints];

  // Scoreboard: keeps its own copy of the registers and the joint history,
  // predicts the result of every accepted sample and checks the results.
  class torque_scoreboard;
    logic [CfgDataW-1:0] visc_pos, visc_neg, coul_pos, coul_neg, slope, thresh;
    logic [CoefW-1:0]    scale;
    int                  prev_angle [NumJoints];
    int                  vel_one [NumJoints];
    int                  vel_two [NumJoints];
    logic [OutDataW-1:0] expected_q [$];
    int                  errors;

    function new();
      visc_pos = '0;
      visc_neg = '0;
      coul_pos = '0;
      coul_neg = '0;
      slope    = '0;
      thresh   = '0;
      scale    = jfc_pkg::FRIC_SCALE_RESET;
      errors   = 0;
      for (int j = 0; j < NumJoints; j++) begin
        prev_angle[j] = 0;
        vel_one[j]    = 0;
        vel_two[j]    = 0;
      end
    endfunction

    function void write_register(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
      case (idx)
        jfc_pkg::REG_VISC_POS:   visc_pos = val;
        jfc_pkg::REG_VISC_NEG:   visc_neg = val;
        jfc_pkg::REG_COUL_POS:   coul_pos = val;
        jfc_pkg::REG_COUL_NEG:   coul_neg = val;
        jfc_pkg::REG_DB_SLOPE:   slope    = val;
        jfc_pkg::REG_THRESH:     thresh   = val;
        jfc_pkg::REG_FRIC_SCALE: scale    = val[CoefW-1:0];
        default: ;
      endcase
    endfunction

    static function longint lane_s(logic [CfgDataW-1:0] r, int j);
      return longint'($signed(r[CoefW*j +: CoefW]));
    endfunction

    static function longint lane_u(logic [CfgDataW-1:0] r, int j);
      return longint'({48'd0, r[CoefW*j +: CoefW]});
    endfunction

    static function int clamp32(longint x);
      if (x > SatHi) return int'(SatHi);
      if (x < SatLo) return int'(SatLo);
      return int'(x);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Predict the result of one accepted sample and advance the history.
    function void note_angles(logic [InDataW-1:0] d);
      logic [OutDataW-1:0] res;
      longint ang, sum, v, thr, u;
      int vel;
      for (int j = 0; j < NumJoints; j++) begin
        ang = longint'($signed(d[AngleW*j +: AngleW]));
        sum = (ang - longint'(prev_angle[j])) * 1000
            + longint'(vel_one[j]) + longint'(vel_two[j]);
        vel = clamp32(sum / 3);
        v   = longint'(vel);
        thr = lane_u(thresh, j) * 16;
        prev_angle[j] = int'(ang);
        vel_two[j]    = vel_one[j];
        vel_one[j]    = vel;
        // A zero threshold sends a zero velocity down the positive branch.
        if (v >= thr)
          u = ((lane_s(visc_pos, j) * v) >>> 12) + lane_s(coul_pos, j) * 16;
        else if (v <= -thr)
          u = ((lane_s(visc_neg, j) * v) >>> 12) + lane_s(coul_neg, j) * 16;
        else
          u = (lane_s(slope, j) * v) >>> 12;
        res[AngleW*j +: AngleW] = clamp32((u * longint'({48'd0, scale})) >>> 12);
        res[AngleW*(NumJoints+j) +: AngleW] = vel;
      end
      expected_q.push_back(res);
    endfunction

    static function string field_name(int k);
      case (k)
        0: return "friction_torque_joint1";
        1: return "friction_torque_joint2";
        2: return "friction_torque_joint3";
        3: return "velocity_joint1";
        4: return "velocity_joint2";
        default: return "velocity_joint3";
      endcase
    endfunction

    // Compare one result transaction with the oldest prediction.
    function void check_result(logic [OutDataW-1:0] d);
      logic [OutDataW-1:0] exp_word;
      if (expected_q.size() == 0) begin
        if (errors < 10)
          $display("unexpected result transaction: 0x%h", d);
        errors++;
        return;
      end
      exp_word = expected_q.pop_front();
      for (int k = 0; k < 2 * NumJoints; k++) begin
        if (d[AngleW*k +: AngleW] !== exp_word[AngleW*k +: AngleW]) begin
          if (errors < 10)
            $display("mismatch in %s: expected %0d (0x%08h), got %0d (0x%08h)",
                     field_name(k), $signed(exp_word[AngleW*k +: AngleW]),
                     exp_word[AngleW*k +: AngleW], $signed(d[AngleW*k +: AngleW]),
                     d[AngleW*k +: AngleW]);
          errors++;
        end
      end
    endfunction
  endclass

  torque_scoreboard board = new();

  joint_friction_compensation_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [InDataW-1:0] pack_angles(int a0, int a1, int a2);
    return {a2, a1, a0};
  endfunction

  // Next random sample: mostly small steps of varied size around the last
  // angle, sometimes a held angle or a completely random one.
  function automatic logic [InDataW-1:0] next_angles();
    int mode;
    int span;
    for (int j = 0; j < NumJoints; j++) begin
      mode = $urandom_range(0, 99);
      if (mode < 8) begin
        walk[j] = int'($urandom);
      end else if (mode >= 13) begin
        span = 1 << (4 * $urandom_range(0, 4));
        walk[j] += int'($urandom_range(0, 2 * span)) - span;
      end
    end
    return pack_angles(walk[0], walk[1], walk[2]);
  endfunction

  // Observe both channels; every transaction is seen at its accepting edge.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      board.check_result(out_tdata);
    if (rst_n && in_tvalid && in_tready)
      board.note_angles(in_tdata);
  end

  // Result channel back-pressure.
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        out_tready <= 1'b0;
        hold--;
      end else if (!idling || $urandom_range(0, 99) < 70) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b0;
        hold = pick_gap() - 1;
      end
    end
  end

  // Called at a clock edge; returns at the edge that accepts the sample.
  task automatic send_angles(input logic [InDataW-1:0] d);
    int gap;
    gap = (idling && $urandom_range(0, 1) == 1) ? pick_gap() : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    do @(posedge clk); while (!in_tready);
  endtask

  // Leaves the write enable high; the caller lowers it after the last write.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    board.write_register(idx, val);
  endtask

  // Stop sending and wait until every predicted result has arrived.
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
  endtask

  // Register setting of one phase: three extreme settings, then random ones.
  task automatic load_phase_config(input int kind);
    logic [CfgDataW-1:0] coef [5];
    logic [CfgDataW-1:0] th;
    logic [CfgDataW-1:0] sc;
    case (kind)
      0: begin
        foreach (coef[i]) coef[i] = '1;
        th = '1;
        sc = '1;
      end
      1: begin
        foreach (coef[i]) coef[i] = {3{16'h7fff}};
        th = '0;
        sc = '0;
      end
      2: begin
        foreach (coef[i]) coef[i] = {3{16'h8000}};
        th = {3{16'h8000}};
        sc = {32'h5a5a_a5a5, 16'h1000};
      end
      default: begin
        foreach (coef[i]) coef[i] = 48'({$urandom, $urandom});
        for (int j = 0; j < NumJoints; j++)
          th[CoefW*j +: CoefW] = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                              : 16'($urandom_range(0, 2048));
        sc = 48'({$urandom, $urandom});
        if ($urandom_range(0, 1) == 1) sc[47:16] = '0;
      end
    endcase
    write_reg(jfc_pkg::REG_VISC_POS, coef[0]);
    write_reg(jfc_pkg::REG_VISC_NEG, coef[1]);
    write_reg(jfc_pkg::REG_COUL_POS, coef[2]);
    write_reg(jfc_pkg::REG_COUL_NEG, coef[3]);
    write_reg(jfc_pkg::REG_DB_SLOPE, coef[4]);
    write_reg(jfc_pkg::REG_THRESH, th);
    write_reg(jfc_pkg::REG_FRIC_SCALE, sc);
    write_reg(RegUnmapped, 48'({$urandom, $urandom}));
    cfg_we <= 1'b0;
  endtask

  // Main sequence.
  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed setting; the scale keeps its reset value of one. Joint 1 has
    // a zero threshold, joints 2 and 3 a threshold of exactly 2000 (Q15.16),
    // which a step of six from rest hits on the nose.
    write_reg(jfc_pkg::REG_VISC_POS, {16'h0800, 16'h1000, 16'h7fff});
    write_reg(jfc_pkg::REG_VISC_NEG, {16'hf000, 16'h1000, 16'h8000});
    write_reg(jfc_pkg::REG_COUL_POS, {16'h0010, 16'h7fff, 16'h0100});
    write_reg(jfc_pkg::REG_COUL_NEG, {16'hfff0, 16'h8000, 16'hff00});
    write_reg(jfc_pkg::REG_DB_SLOPE, {16'h7fff, 16'hffff, 16'h0400});
    write_reg(jfc_pkg::REG_THRESH,   {16'd125, 16'd125, 16'd0});
    cfg_we <= 1'b0;

    // Zero velocity on a zero threshold, velocity equal to plus and minus
    // the threshold, the deadband, then steps large enough to saturate.
    send_angles(pack_angles(0, 6, -6));
    send_angles(pack_angles(0, 9, -9));
    send_angles(pack_angles(0, 9, -9));
    send_angles(pack_angles(32'h7fffffff, 32'h7fffffff, 32'h80000000));
    send_angles(pack_angles(32'h80000000, 32'h80000000, 32'h7fffffff));
    send_angles(pack_angles(32'h80000000, 32'h80000000, 32'h7fffffff));
    send_angles(pack_angles(0, 0, 0));
    send_angles(pack_angles(32'hffffffff, 1, -1));
    send_angles(pack_angles(32'h55555555, 32'haaaaaaaa, 32'h0f0f0f0f));
    send_angles(pack_angles(32'haaaaaaaa, 32'h55555555, 32'hf0f0f0f0));
    send_angles(pack_angles(0, 0, 0));
    send_angles(pack_angles(0, 0, 0));
    send_angles(pack_angles(0, 0, 0));
    settle();

    for (int j = 0; j < NumJoints; j++) walk[j] = 0;
    for (int phase = 0; phase < NumPhases; phase++) begin
      idling = (phase % 3 != 2);
      load_phase_config(phase);
      repeat (ItemsPerPhase) send_angles(next_angles());
      settle();
    end

    repeat (2 * LatencyCycles) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0)
      $display("** joint_friction_compensation_core: PASSED **");
    else
      $display("** joint_friction_compensation_core: FAILED **");
    $finish;
  end

  // Watchdog.
  initial begin
    #2000000;
    $display("** joint_friction_compensation_core: FAILED **");
    $finish;
  end

endmodule

[joint_friction_compensation_core.f]
rtl/core/jfc_pkg.sv
rtl/core/jfc_lane.sv
rtl/core/jfc_merge.sv
rtl/core/joint_friction_compensation_core.sv
sim/tb.sv
